@@ rtl/sdb_pkg.sv @@
// shared types, codes and constants of the sector deblocking buffer
package sdb_pkg;

    localparam int DISK_W   = 4;
    localparam int TRACK_W  = 16;
    localparam int RECORD_W = 8;
    localparam int SECTOR_W = 6;
    localparam int RUN_W    = 4;
    localparam int RUNREC_W = 16;
    localparam int RPT_W    = 8;
    localparam int OFFSET_W = 32;
    localparam int BOFF_W   = 9;
    localparam int PROD_W   = TRACK_W + RPT_W;

    localparam logic [RPT_W-1:0] RPT_RESET   = 8'd80;
    localparam logic [RUN_W-1:0] UNALLOC_RUN = 4'd15;

    typedef enum logic [1:0] {
        ACT_WRITE_BACK = 2'd0,
        ACT_FILL       = 2'd1,
        ACT_TRANSFER   = 2'd2,
        ACT_SAVE       = 2'd3
    } action_t;

    localparam logic [1:0] WTYPE_ALLOC     = 2'd0;
    localparam logic [1:0] WTYPE_DIRECTORY = 2'd1;
    localparam logic [1:0] WTYPE_UNALLOC   = 2'd2;

    typedef struct packed {
        logic                mode;
        logic [DISK_W-1:0]   disk;
        logic [TRACK_W-1:0]  track;
        logic [RECORD_W-1:0] record;
        logic [1:0]          write_type;
    } req_t;

    typedef struct packed {
        logic                buf_valid;
        logic [DISK_W-1:0]   buf_disk;
        logic [TRACK_W-1:0]  buf_track;
        logic [SECTOR_W-1:0] buf_sector;
        logic                buf_dirty;
        logic [RUN_W-1:0]    run_count;
        logic [DISK_W-1:0]   run_disk;
        logic [TRACK_W-1:0]  run_track;
        logic [RUNREC_W-1:0] run_record;
    } state_t;

    typedef struct packed {
        logic [3:0]          mask;
        logic [DISK_W-1:0]   disk;
        logic [OFFSET_W-1:0] offset;
        logic [DISK_W-1:0]   old_disk;
        logic [OFFSET_W-1:0] old_offset;
        logic [BOFF_W-1:0]   buffer_offset;
        logic                direction;
    } plan_t;

endpackage

@@ rtl/sector_deblocking_buffer_unit.sv @@
// top level of the sector deblocking buffer
// Each record request yields one to four actions on the result stream, one per
// cycle unless m_tready holds them, in the order write-back, fill, transfer, save;
// the last one carries tlast. A request is registered, decided combinationally
// and its actions held in a plan register that the result side drains, one
// action per result handshake. The next request is taken while the current plan
// is still being drained.
module sector_deblocking_buffer_unit
#(
    parameter logic [sdb_pkg::RUN_W-1:0] UNALLOC_RUN = sdb_pkg::UNALLOC_RUN
)
(
    input  logic        clk,
    input  logic        rst_n,
    input  logic        cfg_wr_en,
    input  logic [7:0]  cfg_wr_data,   // records_per_track
    input  logic        s_tvalid,
    output logic        s_tready,
    input  logic [31:0] s_tdata,       // disk, track, record, write_type
    input  logic        s_tuser,       // mode
    output logic        m_tvalid,
    input  logic        m_tready,
    output logic [47:0] m_tdata,       // target_disk, byte_offset, buffer_offset, direction
    output logic [1:0]  m_tuser,       // action
    output logic        m_tlast
);

    logic [sdb_pkg::RPT_W-1:0] rpt_reg;
    logic                      in_valid_reg;
    sdb_pkg::req_t             req_reg;
    sdb_pkg::req_t             req_in;
    sdb_pkg::state_t           state_reg;
    sdb_pkg::state_t           state_next;
    sdb_pkg::plan_t            plan_reg;
    sdb_pkg::plan_t            step_plan;
    logic [3:0]                mask_next;
    sdb_pkg::action_t          cur_act;
    logic                      out_fire;
    logic                      plan_free;
    logic                      plan_load;
    logic                      single;

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
            rpt_reg <= sdb_pkg::RPT_RESET;
        else if (cfg_wr_en)
            rpt_reg <= cfg_wr_data;
    end

    assign req_in.mode       = s_tuser;
    assign req_in.disk       = s_tdata[3:0];
    assign req_in.track      = s_tdata[19:4];
    assign req_in.record     = s_tdata[27:20];
    assign req_in.write_type = s_tdata[29:28];

    // action selection from the plan
    always_comb
    begin
        if (plan_reg.mask[sdb_pkg::ACT_WRITE_BACK])
            cur_act = sdb_pkg::ACT_WRITE_BACK;
        else if (plan_reg.mask[sdb_pkg::ACT_FILL])
            cur_act = sdb_pkg::ACT_FILL;
        else if (plan_reg.mask[sdb_pkg::ACT_TRANSFER])
            cur_act = sdb_pkg::ACT_TRANSFER;
        else
            cur_act = sdb_pkg::ACT_SAVE;
        mask_next          = plan_reg.mask;
        mask_next[cur_act] = 1'b0;
    end

    assign single    = (mask_next == 4'b0);
    assign m_tvalid  = (plan_reg.mask != 4'b0);
    assign out_fire  = m_tvalid && m_tready;
    assign plan_free = !m_tvalid || (out_fire && single);
    assign plan_load = in_valid_reg && plan_free;
    assign s_tready  = !in_valid_reg || plan_load;

    sdb_step
    #(
        .UNALLOC_RUN       (UNALLOC_RUN)
    )
    u_step
    (
        .req               (req_reg),
        .cur               (state_reg),
        .records_per_track (rpt_reg),
        .nxt               (state_next),
        .plan              (step_plan)
    );

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            in_valid_reg <= 1'b0;
            state_reg    <= '0;
            plan_reg     <= '0;
        end
        else
        begin
            if (s_tready)
                in_valid_reg <= s_tvalid;
            if (plan_load)
            begin
                state_reg <= state_next;
                plan_reg  <= step_plan;
            end
            else if (out_fire)
            begin
                plan_reg.mask <= mask_next;
            end
        end
    end

    always_ff @(posedge clk)
    begin
        if (s_tready && s_tvalid)
            req_reg <= req_in;
    end

    always_comb
    begin
        m_tuser = cur_act;
        m_tlast = single;
        m_tdata = '0;
        case (cur_act)
            sdb_pkg::ACT_WRITE_BACK:
            begin
                m_tdata[3:0]  = plan_reg.old_disk;
                m_tdata[35:4] = plan_reg.old_offset;
            end
            sdb_pkg::ACT_TRANSFER:
            begin
                m_tdata[3:0]   = plan_reg.disk;
                m_tdata[35:4]  = plan_reg.offset;
                m_tdata[44:36] = plan_reg.buffer_offset;
                m_tdata[45]    = plan_reg.direction;
            end
            default:
            begin
                m_tdata[3:0]  = plan_reg.disk;
                m_tdata[35:4] = plan_reg.offset;
            end
        endcase
    end

`ifndef SYNTHESIS
    a_plan_has_transfer: assert property (@(posedge clk) disable iff (!rst_n)
        plan_load |=> plan_reg.mask[sdb_pkg::ACT_TRANSFER])
        else $error("loaded plan without record transfer");

    a_last_is_final: assert property (@(posedge clk) disable iff (!rst_n)
        (m_tvalid && m_tlast) |->
            (m_tuser == sdb_pkg::ACT_TRANSFER || m_tuser == sdb_pkg::ACT_SAVE))
        else $error("tlast on an action before the transfer");

    a_save_cleans: assert property (@(posedge clk) disable iff (!rst_n)
        (plan_load && step_plan.mask[sdb_pkg::ACT_SAVE]) |=> !state_reg.buf_dirty)
        else $error("buffer dirty after directory save");
`endif

endmodule

@@ rtl/sdb_step.sv @@
// per-request decision logic: run tracker, tag compare, action set and offsets
module sdb_step
#(
    parameter logic [sdb_pkg::RUN_W-1:0] UNALLOC_RUN = sdb_pkg::UNALLOC_RUN
)
(
    input  sdb_pkg::req_t                 req,
    input  sdb_pkg::state_t               cur,
    input  logic [sdb_pkg::RPT_W-1:0]     records_per_track,
    output sdb_pkg::state_t               nxt,
    output sdb_pkg::plan_t                plan
);

    logic                              wr;
    logic                              fill;
    logic                              miss;
    logic                              advance;
    logic                              save;
    logic [sdb_pkg::SECTOR_W-1:0]      sec;
    logic [sdb_pkg::RUNREC_W-1:0]      base_record;
    logic [sdb_pkg::TRACK_W-1:0]       base_track;
    logic [sdb_pkg::RUNREC_W-1:0]      rec_inc;
    logic [sdb_pkg::PROD_W-1:0]        new_prod;
    logic [sdb_pkg::PROD_W-1:0]        old_prod;

    assign wr  = req.mode;
    assign sec = req.record[sdb_pkg::RECORD_W-1:2];

    // run tracker
    always_comb
    begin
        nxt         = cur;
        fill        = 1'b1;
        advance     = 1'b0;
        base_record = cur.run_record;
        base_track  = cur.run_track;
        if (!wr)
        begin
            nxt.run_count = '0;
        end
        else if (req.write_type == sdb_pkg::WTYPE_UNALLOC)
        begin
            nxt.run_count = UNALLOC_RUN;
            nxt.run_disk  = req.disk;
            base_record   = sdb_pkg::RUNREC_W'(req.record);
            base_track    = req.track;
            advance       = 1'b1;
            fill          = 1'b0;
        end
        else if (cur.run_count != '0)
        begin
            if (cur.run_disk != req.disk || cur.run_track != req.track ||
                cur.run_record != sdb_pkg::RUNREC_W'(req.record))
            begin
                nxt.run_count = '0;
            end
            else
            begin
                nxt.run_count = cur.run_count - sdb_pkg::RUN_W'(1);
                advance       = 1'b1;
                fill          = 1'b0;
            end
        end

        rec_inc = base_record + sdb_pkg::RUNREC_W'(1);
        if (advance)
        begin
            if (rec_inc == sdb_pkg::RUNREC_W'(records_per_track))
            begin
                nxt.run_record = '0;
                nxt.run_track  = base_track + sdb_pkg::TRACK_W'(1);
            end
            else
            begin
                nxt.run_record = rec_inc;
                nxt.run_track  = base_track;
            end
        end

        // buffer tag and dirty mark
        miss = !cur.buf_valid || cur.buf_disk != req.disk ||
               cur.buf_track != req.track || cur.buf_sector != sec;
        save = wr && (req.write_type == sdb_pkg::WTYPE_DIRECTORY);
        if (miss)
        begin
            nxt.buf_valid  = 1'b1;
            nxt.buf_disk   = req.disk;
            nxt.buf_track  = req.track;
            nxt.buf_sector = sec;
            nxt.buf_dirty  = 1'b0;
        end
        if (save)
            nxt.buf_dirty = 1'b0;
        else if (wr)
            nxt.buf_dirty = 1'b1;
    end

    assign new_prod = sdb_pkg::PROD_W'(req.track) * sdb_pkg::PROD_W'(records_per_track);
    assign old_prod = sdb_pkg::PROD_W'(cur.buf_track) * sdb_pkg::PROD_W'(records_per_track);

    always_comb
    begin
        plan                               = '0;
        plan.mask[sdb_pkg::ACT_WRITE_BACK] = miss && cur.buf_valid && cur.buf_dirty;
        plan.mask[sdb_pkg::ACT_FILL]       = miss && fill;
        plan.mask[sdb_pkg::ACT_TRANSFER]   = 1'b1;
        plan.mask[sdb_pkg::ACT_SAVE]       = save;
        plan.disk          = req.disk;
        plan.offset        = sdb_pkg::OFFSET_W'({new_prod, 7'b0}) +
                             sdb_pkg::OFFSET_W'({sec, 9'b0});
        plan.old_disk      = cur.buf_disk;
        plan.old_offset    = sdb_pkg::OFFSET_W'({old_prod, 7'b0}) +
                             sdb_pkg::OFFSET_W'({cur.buf_sector, 9'b0});
        plan.buffer_offset = {req.record[1:0], 7'b0};
        plan.direction     = wr;
    end

endmodule

@@ verif/sdb_result_checker.sv @@
// scoreboard for the sector deblocking buffer: predicts the action stream and compares it
module sdb_result_checker
(
    input  logic        clk,
    input  logic        rst_n,
    input  logic        cfg_wr_en,
    input  logic [7:0]  cfg_wr_data,
    input  logic        s_tvalid,
    input  logic        s_tready,
    input  logic [31:0] s_tdata,
    input  logic        s_tuser,
    input  logic        m_tvalid,
    input  logic        m_tready,
    input  logic [47:0] m_tdata,
    input  logic [1:0]  m_tuser,
    input  logic        m_tlast,
    output int          fail_count,
    output int          pending
);
    timeunit 1ns;
    timeprecision 1ps;

    typedef struct {
        sdb_pkg::action_t             action;
        logic [sdb_pkg::DISK_W-1:0]   disk;
        logic [sdb_pkg::OFFSET_W-1:0] offset;
        logic [sdb_pkg::BOFF_W-1:0]   buffer_offset;
        logic                         direction;
        logic                         last;
    } sector_action_t;

    sector_action_t expected_actions[$];

    logic [sdb_pkg::RPT_W-1:0]    rpt;
    logic                         buf_valid;
    logic [sdb_pkg::DISK_W-1:0]   buf_disk;
    logic [sdb_pkg::TRACK_W-1:0]  buf_track;
    logic [sdb_pkg::SECTOR_W-1:0] buf_sector;
    logic                         buf_dirty;
    logic [sdb_pkg::RUN_W-1:0]    run_count;
    logic [sdb_pkg::DISK_W-1:0]   run_disk;
    logic [sdb_pkg::TRACK_W-1:0]  run_track;
    logic [sdb_pkg::RUNREC_W-1:0] run_record;

    initial
    begin
        fail_count = 0;
        pending    = 0;
    end

    function automatic logic [sdb_pkg::OFFSET_W-1:0] image_offset(
        logic [sdb_pkg::TRACK_W-1:0] trk, logic [sdb_pkg::SECTOR_W-1:0] sec);
        return ({16'd0, trk} * {24'd0, rpt}) * 32'd128 + {26'd0, sec} * 32'd512;
    endfunction

    task automatic step_run_position();
        run_record = run_record + 16'd1;
        if (run_record == {8'd0, rpt})
        begin
            run_record = '0;
            run_track  = run_track + 16'd1;
        end
    endtask

    task automatic add_action(sdb_pkg::action_t act, logic [sdb_pkg::DISK_W-1:0] dsk,
                              logic [sdb_pkg::OFFSET_W-1:0] off,
                              logic [sdb_pkg::BOFF_W-1:0] boff, logic dir, logic fin);
        sector_action_t a;
        a.action        = act;
        a.disk          = dsk;
        a.offset        = off;
        a.buffer_offset = boff;
        a.direction     = dir;
        a.last          = fin;
        expected_actions.push_back(a);
    endtask

    task automatic plan_request(logic wr, logic [sdb_pkg::DISK_W-1:0] dsk,
                                logic [sdb_pkg::TRACK_W-1:0] trk,
                                logic [sdb_pkg::RECORD_W-1:0] rec, logic [1:0] wtype);
        logic [sdb_pkg::SECTOR_W-1:0] sec;
        logic                         fill;
        logic                         save_now;
        sec      = rec[7:2];
        fill     = 1'b1;
        save_now = wr && (wtype == sdb_pkg::WTYPE_DIRECTORY);

        if (!wr)
            run_count = '0;
        else if (wtype == sdb_pkg::WTYPE_UNALLOC)
        begin
            run_count  = sdb_pkg::UNALLOC_RUN;
            run_disk   = dsk;
            run_track  = trk;
            run_record = {8'd0, rec};
            step_run_position();
            fill = 1'b0;
        end
        else if (run_count != '0)
        begin
            run_count = run_count - 4'd1;
            if (run_disk != dsk || run_track != trk || run_record != {8'd0, rec})
                run_count = '0;
            else
            begin
                step_run_position();
                fill = 1'b0;
            end
        end

        if (!buf_valid || buf_disk != dsk || buf_track != trk || buf_sector != sec)
        begin
            if (buf_valid && buf_dirty)
                add_action(sdb_pkg::ACT_WRITE_BACK, buf_disk,
                           image_offset(buf_track, buf_sector), '0, 1'b0, 1'b0);
            buf_dirty  = 1'b0;
            buf_valid  = 1'b1;
            buf_disk   = dsk;
            buf_track  = trk;
            buf_sector = sec;
            if (fill)
                add_action(sdb_pkg::ACT_FILL, dsk, image_offset(trk, sec), '0, 1'b0, 1'b0);
        end

        add_action(sdb_pkg::ACT_TRANSFER, dsk, image_offset(trk, sec), {rec[1:0], 7'd0}, wr,
                   !save_now);
        if (wr)
            buf_dirty = 1'b1;
        if (save_now)
        begin
            add_action(sdb_pkg::ACT_SAVE, buf_disk, image_offset(buf_track, buf_sector), '0,
                       1'b0, 1'b1);
            buf_dirty = 1'b0;
        end
    endtask

    task automatic note_field(string field, longint unsigned want, longint unsigned got);
        if (want != got)
        begin
            $error("%s: expected %0d, actual %0d", field, want, got);
            fail_count++;
        end
    endtask

    task automatic check_action();
        sector_action_t want;
        if (expected_actions.size() == 0)
        begin
            $error("action %0d arrived with no request outstanding", m_tuser);
            fail_count++;
        end
        else
        begin
            want = expected_actions.pop_front();
            note_field("action", want.action, m_tuser);
            note_field("target_disk", want.disk, m_tdata[3:0]);
            note_field("byte_offset", want.offset, m_tdata[35:4]);
            note_field("buffer_offset", want.buffer_offset, m_tdata[44:36]);
            note_field("direction", want.direction, m_tdata[45]);
            note_field("last", want.last, m_tlast);
        end
    endtask

    always @(posedge clk)
    begin
        if (!rst_n)
        begin
            rpt        = sdb_pkg::RPT_RESET;
            buf_valid  = 1'b0;
            buf_disk   = '0;
            buf_track  = '0;
            buf_sector = '0;
            buf_dirty  = 1'b0;
            run_count  = '0;
            run_disk   = '0;
            run_track  = '0;
            run_record = '0;
            expected_actions.delete();
            pending <= 0;
        end
        else
        begin
            // results of older requests leave before a new request is planned
            if (m_tvalid && m_tready)
                check_action();
            if (s_tvalid && s_tready)
                plan_request(s_tuser, s_tdata[3:0], s_tdata[19:4], s_tdata[27:20],
                             s_tdata[29:28]);
            if (cfg_wr_en)
                rpt = cfg_wr_data;
            pending <= expected_actions.size();
        end
    end

endmodule

@@ verif/sector_deblocking_buffer_unit_tb.sv @@
// testbench top for the sector deblocking buffer: request stimulus, result back-pressure, verdict
module sector_deblocking_buffer_unit_tb;
    timeunit 1ns;
    timeprecision 1ps;

    localparam logic       MODE_READ   = 1'b0;
    localparam logic       MODE_WRITE  = 1'b1;
    localparam logic [1:0] WTYPE_SPARE = 2'd3;
    localparam int         IDLE_LIMIT  = 5000;
    localparam int         PHASE_ITEMS = 22;

    typedef enum int {
        READY_ALWAYS,
        READY_RANDOM,
        READY_EVERY_FOURTH,
        READY_SPARSE
    } ready_style_t;

    logic        clk;
    logic        rst_n;
    logic        cfg_wr_en;
    logic [7:0]  cfg_wr_data;
    logic        s_tvalid;
    logic        s_tready;
    logic [31:0] s_tdata;
    logic        s_tuser;
    logic        m_tvalid;
    logic        m_tready = 1'b0;
    logic [47:0] m_tdata;
    logic [1:0]  m_tuser;
    logic        m_tlast;

    int           fail_count;
    int           pending;
    int           idle_cycles = 0;
    int           burst_left  = 0;
    int           phase_items = 0;
    int           rdy_left    = 0;
    ready_style_t rdy_style   = READY_ALWAYS;
    logic [7:0]   cur_rpt     = sdb_pkg::RPT_RESET;

    sector_deblocking_buffer_unit i_dut (
        .clk         (clk),
        .rst_n       (rst_n),
        .cfg_wr_en   (cfg_wr_en),
        .cfg_wr_data (cfg_wr_data),
        .s_tvalid    (s_tvalid),
        .s_tready    (s_tready),
        .s_tdata     (s_tdata),
        .s_tuser     (s_tuser),
        .m_tvalid    (m_tvalid),
        .m_tready    (m_tready),
        .m_tdata     (m_tdata),
        .m_tuser     (m_tuser),
        .m_tlast     (m_tlast)
    );

    sdb_result_checker i_checker (
        .clk         (clk),
        .rst_n       (rst_n),
        .cfg_wr_en   (cfg_wr_en),
        .cfg_wr_data (cfg_wr_data),
        .s_tvalid    (s_tvalid),
        .s_tready    (s_tready),
        .s_tdata     (s_tdata),
        .s_tuser     (s_tuser),
        .m_tvalid    (m_tvalid),
        .m_tready    (m_tready),
        .m_tdata     (m_tdata),
        .m_tuser     (m_tuser),
        .m_tlast     (m_tlast),
        .fail_count  (fail_count),
        .pending     (pending)
    );

    initial
    begin
        clk = 1'b0;
        forever #5 clk = ~clk;
    end

    always @(posedge clk)
    begin
        if (!rst_n)
            m_tready <= 1'b0;
        else
        begin
            if (rdy_left == 0)
            begin
                rdy_style <= ready_style_t'($urandom_range(0, 3));
                rdy_left  <= $urandom_range(16, 96);
            end
            else
                rdy_left <= rdy_left - 1;
            case (rdy_style)
                READY_ALWAYS:       m_tready <= 1'b1;
                READY_RANDOM:       m_tready <= 1'($urandom_range(0, 1));
                READY_EVERY_FOURTH: m_tready <= (rdy_left % 4 == 0);
                default:            m_tready <= ($urandom_range(0, 7) == 0);
            endcase
        end
    end

    always @(posedge clk)
    begin
        if (!rst_n)
            idle_cycles <= 0;
        else if ((s_tvalid && s_tready) || (m_tvalid && m_tready))
            idle_cycles <= 0;
        else if (idle_cycles == IDLE_LIMIT)
        begin
            $display("Verification failed");
            $finish;
        end
        else
            idle_cycles <= idle_cycles + 1;
    end

    task automatic send_req(logic mode, logic [3:0] disk, logic [15:0] track,
                            logic [7:0] record, logic [1:0] wtype);
        int gap;
        if (burst_left == 0)
        begin
            gap = ($urandom_range(0, 3) == 0) ? 0 : $urandom_range(1, 12);
            if (gap > 0)
            begin
                s_tvalid <= 1'b0;
                repeat (gap) @(posedge clk);
            end
            burst_left = $urandom_range(1, 24);
        end
        burst_left--;
        s_tvalid <= 1'b1;
        s_tdata  <= {2'b00, wtype, record, track, disk};
        s_tuser  <= mode;
        do
            @(posedge clk);
        while (!s_tready);
        phase_items++;
    endtask

    task automatic drain_requests();
        s_tvalid <= 1'b0;
        @(posedge clk);
        while (pending != 0)
            @(posedge clk);
    endtask

    task automatic write_rpt(logic [7:0] value);
        drain_requests();
        repeat (8) @(posedge clk);
        cfg_wr_en   <= 1'b1;
        cfg_wr_data <= value;
        @(posedge clk);
        cfg_wr_en <= 1'b0;
        cur_rpt = value;
    endtask

    function automatic logic [3:0] pick_disk();
        return ($urandom_range(0, 3) == 0) ? 4'($urandom_range(0, 15)) : 4'($urandom_range(0, 1));
    endfunction

    function automatic logic [15:0] pick_track();
        case ($urandom_range(0, 9))
            0:       return 16'hFFFF;
            1:       return 16'($urandom_range(0, 65535));
            default: return 16'($urandom_range(0, 3));
        endcase
    endfunction

    function automatic logic [1:0] pick_wtype();
        case ($urandom_range(0, 9))
            6, 7:    return sdb_pkg::WTYPE_DIRECTORY;
            8:       return WTYPE_SPARE;
            9:       return sdb_pkg::WTYPE_UNALLOC;
            default: return sdb_pkg::WTYPE_ALLOC;
        endcase
    endfunction

    // unallocated write followed by writes that mostly follow the run position
    task automatic run_sequence();
        logic [3:0]  d;
        logic [15:0] t;
        logic [15:0] r;
        d = pick_disk();
        t = pick_track();
        r = (cur_rpt == 0) ? 16'($urandom_range(0, 255)) : 16'($urandom_range(0, cur_rpt - 1));
        if ($urandom_range(0, 3) == 0 && cur_rpt > 4)
            r = 16'(cur_rpt - $urandom_range(1, 3));
        send_req(MODE_WRITE, d, t, r[7:0], sdb_pkg::WTYPE_UNALLOC);
        repeat ($urandom_range(1, 17))
        begin
            r = r + 16'd1;
            if (r == {8'd0, cur_rpt})
            begin
                r = '0;
                t = t + 16'd1;
            end
            case ($urandom_range(0, 19))
                0:       send_req(MODE_READ, d, t, r[7:0], pick_wtype());
                1, 2:    send_req(MODE_WRITE, d, t, 8'($urandom_range(0, 255)), pick_wtype());
                default: send_req(MODE_WRITE, d, t, r[7:0], pick_wtype());
            endcase
        end
    endtask

    // requests clustered around a few sectors of one track
    task automatic local_sequence();
        logic [3:0]  d;
        logic [15:0] t;
        logic [7:0]  base;
        d    = pick_disk();
        t    = pick_track();
        base = 8'($urandom_range(0, 255));
        repeat ($urandom_range(2, 8))
            send_req(1'($urandom_range(0, 1)), d, t, base + 8'($urandom_range(0, 7)), pick_wtype());
    endtask

    initial
    begin
        logic [7:0] rpt_plan [6];
        rst_n       = 1'b0;
        cfg_wr_en   = 1'b0;
        cfg_wr_data = '0;
        s_tvalid    = 1'b0;
        s_tdata     = '0;
        s_tuser     = 1'b0;
        repeat (9) @(posedge clk);
        rst_n <= 1'b1;

        // directed part at the reset track length
        send_req(MODE_READ,  4'd3,  16'd10,    8'd5,   sdb_pkg::WTYPE_ALLOC);
        send_req(MODE_READ,  4'd3,  16'd10,    8'd6,   sdb_pkg::WTYPE_ALLOC);
        send_req(MODE_WRITE, 4'd3,  16'd10,    8'd7,   sdb_pkg::WTYPE_ALLOC);
        send_req(MODE_READ,  4'd3,  16'd10,    8'd8,   sdb_pkg::WTYPE_ALLOC);
        send_req(MODE_WRITE, 4'd3,  16'd10,    8'd8,   sdb_pkg::WTYPE_DIRECTORY);
        send_req(MODE_WRITE, 4'd3,  16'd10,    8'd9,   WTYPE_SPARE);
        send_req(MODE_WRITE, 4'd5,  16'd11,    8'd0,   sdb_pkg::WTYPE_DIRECTORY);
        send_req(MODE_WRITE, 4'd15, 16'hFFFF,  8'd255, sdb_pkg::WTYPE_UNALLOC);
        send_req(MODE_WRITE, 4'd15, 16'hFFFF,  8'd0,   sdb_pkg::WTYPE_ALLOC);
        send_req(MODE_WRITE, 4'd0,  16'd0,     8'd79,  sdb_pkg::WTYPE_UNALLOC);
        send_req(MODE_WRITE, 4'd0,  16'd1,     8'd0,   sdb_pkg::WTYPE_ALLOC);
        send_req(MODE_WRITE, 4'd0,  16'd1,     8'd1,   sdb_pkg::WTYPE_ALLOC);
        send_req(MODE_WRITE, 4'd0,  16'd1,     8'd2,   sdb_pkg::WTYPE_DIRECTORY);
        send_req(MODE_READ,  4'd0,  16'd1,     8'd3,   sdb_pkg::WTYPE_UNALLOC);
        send_req(MODE_WRITE, 4'd0,  16'd1,     8'd4,   sdb_pkg::WTYPE_ALLOC);
        send_req(MODE_WRITE, 4'd0,  16'd0,     8'd0,   sdb_pkg::WTYPE_UNALLOC);
        send_req(MODE_WRITE, 4'd1,  16'd0,     8'd1,   sdb_pkg::WTYPE_ALLOC);
        send_req(MODE_WRITE, 4'd2,  16'd100,   8'd200, sdb_pkg::WTYPE_UNALLOC);
        send_req(MODE_READ,  4'd2,  16'd100,   8'd200, WTYPE_SPARE);
        send_req(MODE_READ,  4'd15, 16'hFFFF,  8'd255, sdb_pkg::WTYPE_DIRECTORY);

        rpt_plan = '{8'd255, 8'd1, 8'd0, sdb_pkg::RPT_RESET,
                     8'($urandom_range(1, 255)), 8'($urandom_range(1, 255))};
        foreach (rpt_plan[i])
        begin
            write_rpt(rpt_plan[i]);
            phase_items = 0;
            while (phase_items < PHASE_ITEMS)
            begin
                case ($urandom_range(0, 9))
                    0, 1, 2, 3: run_sequence();
                    4, 5, 6, 7: local_sequence();
                    default:    send_req(1'($urandom_range(0, 1)), 4'($urandom_range(0, 15)),
                                         16'($urandom_range(0, 65535)),
                                         8'($urandom_range(0, 255)), 2'($urandom_range(0, 3)));
                endcase
            end
        end

        drain_requests();
        repeat (20) @(posedge clk);
        if (fail_count == 0 && pending == 0)
            $display("Verification passed");
        else
            $display("Verification failed");
        $finish;
    end

endmodule
